FILE: src/cbg_pkg.sv
// cross blur glow package: shared constants, command flags, sequencer states
// and the blur and glow arithmetic helpers
// depends on nothing
package cbg_pkg;

	// default row store depth
	localparam int MAX_WIDTH_DEF = 32;

	// field widths
	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int GAIN_W   = 8;
	localparam int FW_W     = 6;
	localparam int FH_W     = 8;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int SUM_W    = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

	// register reset values
	localparam logic [GAIN_W-1:0] GAIN_RST   = 8'd0;
	localparam logic [FW_W-1:0]   WIDTH_RST  = 6'd32;
	localparam logic [FH_W-1:0]   HEIGHT_RST = 8'd32;

	// depth of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// divide by six as multiply by ceil(2^13 / 6), exact for sums below 2048
	localparam logic [SUM_W-1:0] DIV6_MUL = 11'd1366;

	// per-word flags produced by the front
	typedef struct packed {
		logic sel;        // store receiving the current row
		logic emit;       // row above exists, one result for this word
		logic up_center;  // second row of the frame, up clamps to centre
		logic flush;      // last word of the frame, whole last row follows
	} cmd_flags_t;

	// back sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_L,
		ST_RD_C,
		ST_RD_R,
		ST_CALC,
		ST_EMIT,
		ST_WR
	} back_state_t;

	// weighted cross sum divided by six
	function automatic logic [CH_W-1:0] div6(input logic [SUM_W-1:0] s);
		logic [2*SUM_W-1:0] p;
		p = s * DIV6_MUL;
		return p[20:13];
	endfunction

	// centre plus scaled blur, saturated
	function automatic logic [CH_W-1:0] glow_add(input logic [CH_W-1:0] c,
			input logic [CH_W-1:0] blur, input logic [GAIN_W-1:0] gain);
		logic [CH_W+GAIN_W-1:0] p;
		logic [CH_W:0]          s;
		p = blur * gain;
		s = {1'b0, c} + {1'b0, p[CH_W+GAIN_W-1:GAIN_W]};
		return s[CH_W] ? {CH_W{1'b1}} : s[CH_W-1:0];
	endfunction

endpackage

FILE: src/cbg_front.sv
// cross blur glow front: accepts pixel words, tracks column, row and store
// select, and classifies each word into a command for the back
// depends on cbg_pkg
module cbg_front
	import cbg_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	output logic                                      in_stall,
	input  logic [CH_W-1:0]                           in_red,
	input  logic [CH_W-1:0]                           in_green,
	input  logic [CH_W-1:0]                           in_blue,
	input  logic [FW_W-1:0]                           frame_width,
	input  logic [FH_W-1:0]                           frame_height,
	input  logic                                      q_full,
	output logic                                      push,
	output logic [PIX_W-1:0]                          cmd_pix,
	output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_x,
	output logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_wlast,
	output cmd_flags_t                                cmd_flags
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [FW_W-1:0] MAXW = FW_W'(MAX_WIDTH);

	logic [XW-1:0]   col_q;
	logic [FH_W-1:0] row_q;
	logic            sel_q;
	logic [XW-1:0]   wlast;
	logic [FH_W-1:0] hlast;
	logic [XW-1:0]   x;
	logic [FH_W-1:0] y;
	logic            last_col;
	logic            last_row;

	// effective frame size, zero and oversize clamped
	always_comb begin
		if (frame_width == '0) begin
			wlast = '0;
		end else if (frame_width > MAXW) begin
			wlast = XW'(MAX_WIDTH - 1);
		end else begin
			wlast = XW'(frame_width - 1'b1);
		end
		hlast = (frame_height == '0) ? '0 : frame_height - 1'b1;
	end

	// position of this word, clamped after a shrink
	assign x        = (col_q > wlast) ? wlast : col_q;
	assign y        = (row_q > hlast) ? hlast : row_q;
	assign last_col = (x == wlast);
	assign last_row = (y == hlast);

	// handshake toward the queue
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// command contents
	assign cmd_pix             = {in_blue, in_green, in_red};
	assign cmd_x               = x;
	assign cmd_wlast           = wlast;
	assign cmd_flags.sel       = sel_q;
	assign cmd_flags.emit      = (y != '0);
	assign cmd_flags.up_center = (y == FH_W'(1));
	assign cmd_flags.flush     = last_col && last_row;

	// raster position and store select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			sel_q <= 1'b0;
		end else if (push) begin
			if (last_col && last_row) begin
				col_q <= '0;
				row_q <= '0;
				sel_q <= !sel_q;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= y + 1'b1;
				sel_q <= !sel_q;
			end else begin
				col_q <= x + 1'b1;
				row_q <= y;
			end
		end
	end

endmodule

FILE: src/cbg_queue.sv
// cross blur glow command queue: short fifo between front and back
// depends on cbg_pkg
module cbg_queue
	import cbg_pkg::*;
#(
	parameter int DATA_W = 32,
	parameter int DEPTH  = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] din,
	output logic              full,
	input  logic              pop,
	output logic              valid,
	output logic [DATA_W-1:0] dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign dout    = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/cbg_back.sv
// cross blur glow back: two row stores, a read sequencer over the cross
// neighbours, blur and glow arithmetic, and the output register
// depends on cbg_pkg
module cbg_back
	import cbg_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      q_valid,
	output logic                                      q_pop,
	input  logic [PIX_W-1:0]                          cmd_pix,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_x,
	input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] cmd_wlast,
	input  cmd_flags_t                                cmd_flags,
	input  logic [GAIN_W-1:0]                         glow_gain,
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic [CH_W-1:0]                           out_red,
	output logic [CH_W-1:0]                           out_green,
	output logic [CH_W-1:0]                           out_blue,
	output logic                                      frame_end,
	output logic                                      run_last
);

	localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// row stores
	logic [PIX_W-1:0] mem_a [MAX_WIDTH];
	logic [PIX_W-1:0] mem_b [MAX_WIDTH];
	logic [PIX_W-1:0] rd_a_q;
	logic [PIX_W-1:0] rd_b_q;

	// current word
	back_state_t      st_q;
	back_state_t      st_d;
	cmd_flags_t       flags_q;
	logic [PIX_W-1:0] pix_q;
	logic [XW-1:0]    idx_q;
	logic [XW-1:0]    wlast_q;
	logic             flushing_q;

	// neighbour and arithmetic registers
	logic [PIX_W-1:0] l_q;
	logic [PIX_W-1:0] o_q;
	logic [PIX_W-1:0] c_q;
	logic [CH_W-1:0]  blur_q [3];

	// output register
	logic             out_valid_q;
	logic [CH_W-1:0]  out_red_q;
	logic [CH_W-1:0]  out_green_q;
	logic [CH_W-1:0]  out_blue_q;
	logic             frame_end_q;
	logic             run_last_q;

	// control
	logic             out_free;
	logic             out_load;
	logic             mem_we;
	logic             cap_lo;
	logic             cap_c;
	logic             blur_ld;
	logic             last_idx;
	logic             center_is_b;
	logic [XW-1:0]    lft;
	logic [XW-1:0]    rgt;
	logic [XW-1:0]    caddr;
	logic [XW-1:0]    addr_a;
	logic [XW-1:0]    addr_b;
	logic [PIX_W-1:0] crd;
	logic [PIX_W-1:0] ord;
	logic [PIX_W-1:0] up_pix;
	logic [PIX_W-1:0] dn_pix;

	assign out_free = !out_valid_q || !out_stall;
	assign last_idx = (idx_q == wlast_q);

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_valid) begin
					st_d = cmd_flags.emit ? ST_RD_L : ST_WR;
				end
			end
			ST_RD_L: st_d = ST_RD_C;
			ST_RD_C: st_d = ST_RD_R;
			ST_RD_R: st_d = ST_CALC;
			ST_CALC: st_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					if (!flushing_q) begin
						st_d = ST_WR;
					end else begin
						st_d = last_idx ? ST_IDLE : ST_RD_L;
					end
				end
			end
			ST_WR: st_d = flags_q.flush ? ST_RD_L : ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop    = 1'b0;
		mem_we   = 1'b0;
		cap_lo   = 1'b0;
		cap_c    = 1'b0;
		blur_ld  = 1'b0;
		out_load = 1'b0;
		caddr    = idx_q;
		case (st_q)
			ST_IDLE: q_pop = q_valid;
			ST_RD_L: caddr = lft;
			ST_RD_C: cap_lo = 1'b1;
			ST_RD_R: begin
				cap_c = 1'b1;
				caddr = rgt;
			end
			ST_CALC: blur_ld = 1'b1;
			ST_EMIT: out_load = out_free;
			ST_WR:   mem_we = 1'b1;
			default: q_pop = 1'b0;
		endcase
	end

	// neighbour addresses, clamped at the row ends
	assign lft = (idx_q == '0) ? '0 : idx_q - 1'b1;
	assign rgt = (idx_q >= wlast_q) ? wlast_q : idx_q + 1'b1;

	// centre row is the previous row for a normal word, the current one on flush
	assign center_is_b = flushing_q ? flags_q.sel : !flags_q.sel;
	assign addr_a      = center_is_b ? idx_q : caddr;
	assign addr_b      = center_is_b ? caddr : idx_q;
	assign crd         = center_is_b ? rd_b_q : rd_a_q;
	assign ord         = center_is_b ? rd_a_q : rd_b_q;

	// row store write and registered read
	always_ff @(posedge clk) begin
		if (mem_we && !flags_q.sel) begin
			mem_a[idx_q] <= pix_q;
		end
		if (mem_we && flags_q.sel) begin
			mem_b[idx_q] <= pix_q;
		end
		rd_a_q <= mem_a[addr_a];
		rd_b_q <= mem_b[addr_b];
	end

	// up and down neighbours
	always_comb begin
		if (flushing_q) begin
			up_pix = flags_q.emit ? o_q : c_q;
			dn_pix = c_q;
		end else begin
			up_pix = flags_q.up_center ? c_q : o_q;
			dn_pix = pix_q;
		end
	end

	// sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			flushing_q <= 1'b0;
			flags_q    <= '0;
		end else begin
			st_q <= st_d;
			if (q_pop) begin
				flags_q    <= cmd_flags;
				flushing_q <= 1'b0;
			end else if (mem_we && flags_q.flush) begin
				flushing_q <= 1'b1;
			end
		end
	end

	// word payload and index
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_q   <= cmd_pix;
			idx_q   <= cmd_x;
			wlast_q <= cmd_wlast;
		end else if (mem_we && flags_q.flush) begin
			idx_q <= '0;
		end else if (out_load && flushing_q && !last_idx) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	// neighbour capture from the store reads
	always_ff @(posedge clk) begin
		if (cap_lo) begin
			l_q <= crd;
			o_q <= ord;
		end
		if (cap_c) begin
			c_q <= crd;
		end
	end

	// cross sum and divide by six, right neighbour straight from the read
	always_ff @(posedge clk) begin
		if (blur_ld) begin
			for (int k = 0; k < 3; k++) begin
				blur_q[k] <= div6({2'b0, c_q[k*CH_W +: CH_W], 1'b0}
					+ SUM_W'(l_q[k*CH_W +: CH_W])
					+ SUM_W'(crd[k*CH_W +: CH_W])
					+ SUM_W'(up_pix[k*CH_W +: CH_W])
					+ SUM_W'(dn_pix[k*CH_W +: CH_W]));
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// glow and output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_red_q   <= glow_add(c_q[CH_W-1:0], blur_q[0], glow_gain);
			out_green_q <= glow_add(c_q[2*CH_W-1:CH_W], blur_q[1], glow_gain);
			out_blue_q  <= glow_add(c_q[3*CH_W-1:2*CH_W], blur_q[2], glow_gain);
			frame_end_q <= flushing_q && last_idx;
			run_last_q  <= flushing_q ? last_idx : !flags_q.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;
	assign frame_end = frame_end_q;
	assign run_last  = run_last_q;

	// the frame's final word always closes its run
	a_end_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q)
		else $error("frame_end word without run_last");

	// working index stays inside the row
	a_idx_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		st_q != ST_IDLE |-> idx_q <= wlast_q)
		else $error("row index beyond last column");

	// flush mode only for the frame's last word
	a_flush_owner: assert property (@(posedge clk) disable iff (!arst_n)
		flushing_q |-> flags_q.flush)
		else $error("flush pass on a word that does not end the frame");

	// the frame's final result returns the sequencer to idle
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && flushing_q && last_idx |=> st_q == ST_IDLE)
		else $error("sequencer busy after the last flush word");

endmodule

FILE: src/cross_blur_glow.sv
// cross blur glow top: five-point cross blur with additive glow, one row late.
// an emitting word runs three centre-row reads, left, centre and right, then calc and emit.
// a pixel is worked through before the next is popped; a frame's first row only
// writes its store, and the frame's last pixel adds a read, calc and emit pass
// per word of the flushed row, paced by the single read port of each row store.
// reset clears position, store select, sequencer, queue and registers; no sweep.
module cross_blur_glow
	import cbg_pkg::*;
#(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CH_W-1:0]      in_red,
	input  logic [CH_W-1:0]      in_green,
	input  logic [CH_W-1:0]      in_blue,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CH_W-1:0]      out_red,
	output logic [CH_W-1:0]      out_green,
	output logic [CH_W-1:0]      out_blue,
	output logic                 frame_end,
	output logic                 run_last
);

	localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int FLAG_W = $bits(cmd_flags_t);
	localparam int DATA_W = FLAG_W + 2 * XW + PIX_W;

	logic [GAIN_W-1:0] gain_q;
	logic [FW_W-1:0]   width_q;
	logic [FH_W-1:0]   height_q;

	logic              push;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	logic [DATA_W-1:0] q_din;
	logic [DATA_W-1:0] q_dout;
	logic [PIX_W-1:0]  f_pix;
	logic [XW-1:0]     f_x;
	logic [XW-1:0]     f_wlast;
	cmd_flags_t        f_flags;
	logic [PIX_W-1:0]  b_pix;
	logic [XW-1:0]     b_x;
	logic [XW-1:0]     b_wlast;
	cmd_flags_t        b_flags;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data[FW_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[FH_W-1:0];
				default:    gain_q   <= gain_q;
			endcase
		end
	end

	// front: position tracking and classification
	cbg_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_red       (in_red),
		.in_green     (in_green),
		.in_blue      (in_blue),
		.frame_width  (width_q),
		.frame_height (height_q),
		.q_full       (q_full),
		.push         (push),
		.cmd_pix      (f_pix),
		.cmd_x        (f_x),
		.cmd_wlast    (f_wlast),
		.cmd_flags    (f_flags)
	);

	// command word packing
	assign q_din = {f_flags, f_wlast, f_x, f_pix};
	assign {b_flags, b_wlast, b_x, b_pix} = q_dout;

	// queue between front and back
	cbg_queue #(
		.DATA_W (DATA_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	// back: row stores, blur and glow
	cbg_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.cmd_pix   (b_pix),
		.cmd_x     (b_x),
		.cmd_wlast (b_wlast),
		.cmd_flags (b_flags),
		.glow_gain (gain_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_red   (out_red),
		.out_green (out_green),
		.out_blue  (out_blue),
		.frame_end (frame_end),
		.run_last  (run_last)
	);

endmodule
